// ===== hw/rtl/rdft_pkg.sv =====
// Shared types, constants and the sine table generator for the running DFT block.
package rdft_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 16;
    localparam int TRIG_W   = 16;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 48;
    localparam int NODE_W   = 12;
    localparam int FSEL_W   = 2;
    localparam int MAX_FREQ = 4;
    localparam int ROM_W    = 15;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int CFG_W    = 16;

    // pi/2 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 7;
    // (2n)(2n+1) for n = 1..7
    localparam longint unsigned TAYLOR_DIV [1:TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    typedef enum logic [2:0] {
        REG_STEP0 = 3'd0,
        REG_STEP1 = 3'd1,
        REG_STEP2 = 3'd2,
        REG_STEP3 = 3'd3,
        REG_DT    = 3'd4
    } reg_idx_t;

    typedef enum logic {
        FUNC_ACC  = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] real_x;
        logic signed [SUM_W-1:0] imag_x;
        logic signed [SUM_W-1:0] real_y;
        logic signed [SUM_W-1:0] imag_y;
        logic signed [SUM_W-1:0] real_z;
        logic signed [SUM_W-1:0] imag_z;
    } sums_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] real_x;
        logic signed [PROD_W-1:0] imag_x;
        logic signed [PROD_W-1:0] real_y;
        logic signed [PROD_W-1:0] imag_y;
        logic signed [PROD_W-1:0] real_z;
        logic signed [PROD_W-1:0] imag_z;
    } prods_t;

    typedef struct packed {
        logic adv;     // pipeline moves this cycle
        logic wr_en;   // accumulate write from the last stage
        logic clr_en;  // clearing pass write
    } bank_ctrl_t;

    // Quarter-wave sine entry from a Q2.30 angle; evaluated at elaboration only.
    function automatic logic [ROM_W-1:0] quarter_sine(longint unsigned x);
        longint unsigned t;
        longint unsigned s;
        longint unsigned r;
        t = x;
        s = x;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
                s = (t > s) ? 64'd0 : s - t;
            end else begin
                s = s + t;
            end
        end
        r = (s + 64'd16384) >> 15;
        return (r > 64'd32767) ? ROM_W'(32767) : r[ROM_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/rdft_lane.sv =====
// One frequency lane: phase, sine/cosine lookup, dt weighting and sample products.
module rdft_lane import rdft_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       adv,
    input  logic [CFG_W-1:0]           phase_step,
    input  logic [CFG_W-1:0]           dt_gain,
    input  logic [PHASE_W-1:0]         time_step,   // stage 1
    input  logic signed [SAMPLE_W-1:0] sample_x,    // stage 4
    input  logic signed [SAMPLE_W-1:0] sample_y,
    input  logic signed [SAMPLE_W-1:0] sample_z,
    output prods_t                     prods        // stage 5
);

    localparam int TW = $clog2(TABLE_DEPTH + 1);
    localparam int FW = 14 + TW;

    logic [ROM_W-1:0] sine_rom [TABLE_DEPTH+1];

    for (genvar k = 0; k <= TABLE_DEPTH; k++) begin : g_rom
        localparam longint unsigned ANGLE = (HALF_PI_Q30 * longint'(k)) / TABLE_DEPTH;
        assign sine_rom[k] = quarter_sine(ANGLE);
    end

    // stage 2: phase
    logic [2*PHASE_W-1:0]      phase_full;
    logic [PHASE_W-1:0]        phase_reg;

    // stage 3: table magnitudes and signs, registered read
    logic [FW-1:0]             frac_prod;
    logic [TW-1:0]             idx_lo;
    logic [TW-1:0]             idx_hi;
    logic [TW-1:0]             sin_idx;
    logic [TW-1:0]             cos_idx;
    logic [ROM_W-1:0]          sin_mag_reg;
    logic [ROM_W-1:0]          cos_mag_reg;
    logic                      sin_neg_reg;
    logic                      cos_neg_reg;
    logic signed [TRIG_W-1:0]  sin_val;
    logic signed [TRIG_W-1:0]  cos_val;

    // stage 4: weights
    logic signed [CFG_W+TRIG_W:0] ws_full;
    logic signed [CFG_W+TRIG_W:0] wc_full;
    logic signed [TRIG_W-1:0]     ws_reg;
    logic signed [TRIG_W-1:0]     wc_reg;

    prods_t prods_reg;

    assign phase_full = phase_step * time_step;

    assign frac_prod = FW'(phase_reg[13:0]) * FW'(TABLE_DEPTH);
    assign idx_lo    = frac_prod[FW-1:14];
    assign idx_hi    = TW'(TABLE_DEPTH) - idx_lo;
    // odd quadrants run the table backwards; cosine is a quadrant ahead
    assign sin_idx   = phase_reg[14] ? idx_hi : idx_lo;
    assign cos_idx   = phase_reg[14] ? idx_lo : idx_hi;
    assign sin_val   = sin_neg_reg ? -$signed({1'b0, sin_mag_reg})
                                   : $signed({1'b0, sin_mag_reg});
    assign cos_val   = cos_neg_reg ? -$signed({1'b0, cos_mag_reg})
                                   : $signed({1'b0, cos_mag_reg});

    assign ws_full = sin_val * $signed({1'b0, dt_gain}) + (CFG_W+TRIG_W+1)'(32768);
    assign wc_full = cos_val * $signed({1'b0, dt_gain}) + (CFG_W+TRIG_W+1)'(32768);

    always_ff @(posedge aclk) begin
        if (adv) begin
            phase_reg        <= phase_full[PHASE_W-1:0];
            sin_mag_reg      <= sine_rom[sin_idx];
            cos_mag_reg      <= sine_rom[cos_idx];
            sin_neg_reg      <= phase_reg[15];
            cos_neg_reg      <= phase_reg[15] ^ phase_reg[14];
            ws_reg           <= ws_full[CFG_W+TRIG_W-1:CFG_W];
            wc_reg           <= wc_full[CFG_W+TRIG_W-1:CFG_W];
            prods_reg.real_x <= sample_x * wc_reg;
            prods_reg.imag_x <= sample_x * ws_reg;
            prods_reg.real_y <= sample_y * wc_reg;
            prods_reg.imag_y <= sample_y * ws_reg;
            prods_reg.real_z <= sample_z * wc_reg;
            prods_reg.imag_z <= sample_z * ws_reg;
        end
    end

    assign prods = prods_reg;

endmodule

// ===== hw/rtl/rdft_bank.sv =====
// Accumulator memory of one frequency with saturating update and write forwarding.
module rdft_bank import rdft_pkg::*; #(
    parameter int NODE_COUNT = 4096,
    parameter int AW         = 12
) (
    input  logic          aclk,
    input  bank_ctrl_t    ctrl,
    input  logic [AW-1:0] rd_addr,   // stage 4
    input  logic [AW-1:0] wr_addr,   // stage 5
    input  logic [AW-1:0] clr_addr,
    input  prods_t        prods,     // stage 5
    output sums_t         rd_sums    // stage 5, sums before this item
);

    sums_t mem [NODE_COUNT];
    sums_t rd_reg;
    sums_t new_sums;

    function automatic logic signed [SUM_W-1:0] sat_add(
        logic signed [SUM_W-1:0]  a,
        logic signed [PROD_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {{(SUM_W-PROD_W+1){b[PROD_W-1]}}, b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    always_comb begin
        new_sums.real_x = sat_add(rd_reg.real_x, prods.real_x);
        new_sums.imag_x = sat_add(rd_reg.imag_x, prods.imag_x);
        new_sums.real_y = sat_add(rd_reg.real_y, prods.real_y);
        new_sums.imag_y = sat_add(rd_reg.imag_y, prods.imag_y);
        new_sums.real_z = sat_add(rd_reg.real_z, prods.real_z);
        new_sums.imag_z = sat_add(rd_reg.imag_z, prods.imag_z);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clr_en) begin
            mem[clr_addr] <= '0;
        end else if (ctrl.wr_en) begin
            mem[wr_addr] <= new_sums;
        end
    end

    // back-to-back items on one node: take the sum being written now
    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            if (ctrl.wr_en && wr_addr == rd_addr) begin
                rd_reg <= new_sums;
            end else begin
                rd_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_sums = rd_reg;

endmodule

// ===== hw/rtl/running_dft_field_accumulator_core.sv =====
// Top level of the running DFT accumulator: config registers, item pipeline, banks.
//
// Input channel s_*: one item per valid/ready handshake. func FUNC_ACC adds the
// x/y/z samples, weighted by cos and sin of each frequency's phase times dt, into
// the node's accumulators; FUNC_READ asks for the six sums of one node and one
// frequency. Output channel m_*: one item per read, none per accumulate.
// Out-of-range node: accumulate is dropped; out-of-range node or frequency: read gives zeros.
// Pipeline: phase multiply, table lookup, dt weighting, sample multiply, then
// read-modify-write of the node's memory row, then the output register.
// Throughput: one item per cycle while not stalled or clearing; each frequency
// has its own lane and memory bank, and a row written in the last stage is
// forwarded to the item behind.
// Reset: config registers go to zero and a clearing pass zeroes NODE_COUNT rows,
// one row per cycle across all banks; s_ready stays low during the pass.
// APB writes are taken during the clearing pass. Config only while idle.
// Stall: when a result waits with m_ready low, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
module running_dft_field_accumulator_core import rdft_pkg::*; #(
    parameter int NODE_COUNT  = 4096,
    parameter int FREQ_COUNT  = 4,
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_func,
    input  logic [NODE_W-1:0]          s_node_index,
    input  logic [FSEL_W-1:0]          s_freq_index,
    input  logic [PHASE_W-1:0]         s_time_step,
    input  logic signed [SAMPLE_W-1:0] s_sample_x,
    input  logic signed [SAMPLE_W-1:0] s_sample_y,
    input  logic signed [SAMPLE_W-1:0] s_sample_z,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SUM_W-1:0]    m_real_x,
    output logic signed [SUM_W-1:0]    m_imag_x,
    output logic signed [SUM_W-1:0]    m_real_y,
    output logic signed [SUM_W-1:0]    m_imag_y,
    output logic signed [SUM_W-1:0]    m_real_z,
    output logic signed [SUM_W-1:0]    m_imag_z,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready
);

    localparam int AW     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int STAGES = 5;

    typedef struct packed {
        logic                       func;
        logic [NODE_W-1:0]          node;
        logic [FSEL_W-1:0]          fsel;
        logic [PHASE_W-1:0]         ts;
        logic signed [SAMPLE_W-1:0] sx;
        logic signed [SAMPLE_W-1:0] sy;
        logic signed [SAMPLE_W-1:0] sz;
    } item_t;

    // configuration
    logic [CFG_W-1:0] phase_step_reg [MAX_FREQ];
    logic [CFG_W-1:0] dt_gain_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    // item pipeline
    logic [STAGES:1]  vld_reg;
    item_t            item_reg [1:STAGES];
    logic             adv;
    logic             acc_wr;
    logic             rd_ok;

    // clearing pass
    logic             clr_busy_reg;
    logic [AW-1:0]    clr_addr_reg;

    // banks
    bank_ctrl_t       bank_ctrl;
    sums_t            bank_sums [MAX_FREQ];
    sums_t            out_next;
    sums_t            out_reg;
    logic             m_valid_reg;

    // ---------------- APB ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < MAX_FREQ; l++) begin
                phase_step_reg[l] <= '0;
            end
            dt_gain_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_STEP0: phase_step_reg[0] <= pwdata[CFG_W-1:0];
                REG_STEP1: phase_step_reg[1] <= pwdata[CFG_W-1:0];
                REG_STEP2: phase_step_reg[2] <= pwdata[CFG_W-1:0];
                REG_STEP3: phase_step_reg[3] <= pwdata[CFG_W-1:0];
                REG_DT:    dt_gain_reg       <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_STEP0: prdata = PDATA_W'(phase_step_reg[0]);
            REG_STEP1: prdata = PDATA_W'(phase_step_reg[1]);
            REG_STEP2: prdata = PDATA_W'(phase_step_reg[2]);
            REG_STEP3: prdata = PDATA_W'(phase_step_reg[3]);
            REG_DT:    prdata = PDATA_W'(dt_gain_reg);
            default:   prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // everything moves unless a result sits unclaimed in the output register
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && !clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[STAGES-1:1], s_valid && s_ready};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg[1] <= '{func: s_func, node: s_node_index, fsel: s_freq_index,
                             ts: s_time_step, sx: s_sample_x, sy: s_sample_y,
                             sz: s_sample_z};
            for (int k = 2; k <= STAGES; k++) begin
                item_reg[k] <= item_reg[k-1];
            end
        end
    end

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(NODE_COUNT - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    assign acc_wr = adv && vld_reg[STAGES] && item_reg[STAGES].func == FUNC_ACC
                    && 32'(item_reg[STAGES].node) < NODE_COUNT;

    assign bank_ctrl = '{adv: adv, wr_en: acc_wr, clr_en: clr_busy_reg};

    // ---------------- frequency lanes ----------------
    for (genvar l = 0; l < MAX_FREQ; l++) begin : g_freq
        if (l < FREQ_COUNT) begin : g_on
            prods_t lane_prods;

            rdft_lane #(
                .TABLE_DEPTH(TABLE_DEPTH)
            ) u_lane (
                .aclk       (aclk),
                .adv        (adv),
                .phase_step (phase_step_reg[l]),
                .dt_gain    (dt_gain_reg),
                .time_step  (item_reg[1].ts),
                .sample_x   (item_reg[4].sx),
                .sample_y   (item_reg[4].sy),
                .sample_z   (item_reg[4].sz),
                .prods      (lane_prods)
            );

            rdft_bank #(
                .NODE_COUNT(NODE_COUNT),
                .AW        (AW)
            ) u_bank (
                .aclk     (aclk),
                .ctrl     (bank_ctrl),
                .rd_addr  (AW'(item_reg[4].node)),
                .wr_addr  (AW'(item_reg[STAGES].node)),
                .clr_addr (clr_addr_reg),
                .prods    (lane_prods),
                .rd_sums  (bank_sums[l])
            );
        end else begin : g_off
            assign bank_sums[l] = '0;
        end
    end

    // ---------------- result ----------------
    assign rd_ok    = 32'(item_reg[STAGES].node) < NODE_COUNT
                      && 32'(item_reg[STAGES].fsel) < FREQ_COUNT;
    assign out_next = rd_ok ? bank_sums[item_reg[STAGES].fsel] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[STAGES] && item_reg[STAGES].func == FUNC_READ;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_real_x = out_reg.real_x;
    assign m_imag_x = out_reg.imag_x;
    assign m_real_y = out_reg.real_y;
    assign m_imag_y = out_reg.imag_y;
    assign m_real_z = out_reg.real_z;
    assign m_imag_z = out_reg.imag_z;

endmodule

// ===== hw/rtl/rdft_checker.sv =====
// Port-level checks for the running DFT accumulator, bound to the top level.
module rdft_checker import rdft_pkg::*; (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_func,
    input logic [NODE_W-1:0]          s_node_index,
    input logic [FSEL_W-1:0]          s_freq_index,
    input logic [PHASE_W-1:0]         s_time_step,
    input logic signed [SAMPLE_W-1:0] s_sample_x,
    input logic signed [SAMPLE_W-1:0] s_sample_y,
    input logic signed [SAMPLE_W-1:0] s_sample_z,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [SUM_W-1:0]    m_real_x,
    input logic signed [SUM_W-1:0]    m_imag_x,
    input logic signed [SUM_W-1:0]    m_real_y,
    input logic signed [SUM_W-1:0]    m_imag_y,
    input logic signed [SUM_W-1:0]    m_real_z,
    input logic signed [SUM_W-1:0]    m_imag_z,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [PADDR_W-1:0]         paddr,
    input logic [PDATA_W-1:0]         pwdata,
    input logic [PDATA_W-1:0]         prdata,
    input logic                       pready
);

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken straight after reset");

    // a held result freezes the pipeline
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_real_x) && $stable(m_imag_z))
        else $error("stalled result changed");

    // dt register reads back what was written
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && paddr == {REG_DT, 2'b00}
        ##1 paddr == {REG_DT, 2'b00}
        |-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))
        else $error("dt register readback mismatch");

endmodule

bind running_dft_field_accumulator_core rdft_checker u_rdft_checker (.*);
